// ----- sv/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the battery status conditioner
// Configuration record, register indexes, pin classes and fixed thresholds.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // APB address width: eight 32-bit registers at 4-byte stride
  localparam int ADDR_W = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_EMPTY_MV          = 3'd0;
  localparam logic [2:0] REG_FULL_MV           = 3'd1;
  localparam logic [2:0] REG_OUTLIER_MV        = 3'd2;
  localparam logic [2:0] REG_PLUGGED_ABS_MV    = 3'd3;
  localparam logic [2:0] REG_PLUGGED_MARGIN_MV = 3'd4;
  localparam logic [2:0] REG_BASE_TRACK_MAX_MV = 3'd5;
  localparam logic [2:0] REG_CHG_BAND_MIN      = 3'd6;
  localparam logic [2:0] REG_IDLE_HIGH_MAX     = 3'd7;

  // register reset values
  localparam logic [12:0] RST_EMPTY_MV          = 13'd3300;
  localparam logic [12:0] RST_FULL_MV           = 13'd4050;
  localparam logic [9:0]  RST_OUTLIER_MV        = 10'd100;
  localparam logic [12:0] RST_PLUGGED_ABS_MV    = 13'd4155;
  localparam logic [9:0]  RST_PLUGGED_MARGIN_MV = 10'd110;
  localparam logic [12:0] RST_BASE_TRACK_MAX_MV = 13'd4140;
  localparam logic [5:0]  RST_CHG_BAND_MIN      = 6'd22;
  localparam logic [5:0]  RST_IDLE_HIGH_MAX     = 6'd12;

  // pin classes
  localparam logic [1:0] CLS_HOLD = 2'd0;
  localparam logic [1:0] CLS_IDLE = 2'd1;
  localparam logic [1:0] CLS_CHG  = 2'd2;

  // fixed thresholds
  localparam logic [7:0]         STREAK_MAX      = 8'd255;
  localparam logic [7:0]         CONFIRM_COUNT   = 8'd3;
  localparam logic signed [14:0] FAST_GAP_MV     = 15'sd250;
  localparam logic [12:0]        CONNECT_MAX_MV  = 13'd4350;
  localparam logic [13:0]        EMPTY_MARGIN_MV = 14'd100;
  localparam logic [13:0]        FULL_MARGIN_MV  = 14'd20;
  localparam logic [1:0]         STABLE_FULL     = 2'd2;
  localparam logic [6:0]         SOC_FULL        = 7'd100;
  localparam logic [7:0]         SOC_DEC_GAP     = 8'd16;

  typedef struct packed {
    logic [12:0] empty_mv;
    logic [12:0] full_mv;
    logic [9:0]  outlier_mv;
    logic [12:0] plugged_abs_mv;
    logic [9:0]  plugged_margin_mv;
    logic [12:0] baseline_track_max_mv;
    logic [5:0]  charging_band_min;
    logic [5:0]  idle_high_max;
  } cfg_t;

  // voltage tracker results for the current beat
  typedef struct packed {
    logic [12:0] filt;
    logic [12:0] base;
  } volt_t;

  // charge status for the current beat
  typedef struct packed {
    logic charging;
    logic plugged;
  } charge_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == STREAK_MAX) ? v : v + 8'd1;
  endfunction

endpackage

// ----- sv/battery_status_conditioner.sv -----
// ----------------------------------------------------------------------------
// battery_status_conditioner: battery voltage, charge and SOC conditioning
// Input register, combinational state update, result register.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register, then its state update is
//   written to the result register when that register is free or drained.
// Throughput: one item per cycle unless the result side stalls; each item's
//   state update is registered as it advances, so the next item sees it.
// Reset (rst, synchronous): state and registers to their defaults, both
//   pipeline registers empty. No clearing pass.
// ----------------------------------------------------------------------------
module battery_status_conditioner #(
  parameter int PIN_SAMPLES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [12:0]                raw_mv,
  input  logic [5:0]                 charge_lows,
  input  logic [6:0]                 raw_soc,
  // result channel
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [12:0]                filtered_mv,
  output logic                       charging,
  output logic                       plugged,
  output logic                       connected,
  output logic [6:0]                 shown_soc,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  bsc_pkg::cfg_t    cfg;
  bsc_pkg::volt_t   volt_nx;
  bsc_pkg::charge_t chg_nx;

  // input register
  logic        inq_valid;
  logic [12:0] raw_mv_q;
  logic [5:0]  charge_lows_q;
  logic [6:0]  raw_soc_q;

  // set after the first item; while clear, the item loads the filter instead of updating it
  logic        volt_valid;

  logic        advance;
  logic        first;
  logic [6:0]  shown_nx;

  // the held item moves on whenever the result register is free this cycle
  assign advance    = inq_valid && (!result_valid || result_ready);
  assign item_ready = !inq_valid || advance;
  assign first      = !volt_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (item_ready) begin
      inq_valid <= item_valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      raw_mv_q      <= raw_mv;
      charge_lows_q <= charge_lows;
      raw_soc_q     <= raw_soc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_valid <= 1'b0;
    end else if (advance) begin
      volt_valid <= 1'b1;
    end
  end

  bsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsc_volt u_volt (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .first   (first),
    .raw_mv  (raw_mv_q),
    .cfg     (cfg),
    .volt_nx (volt_nx)
  );

  bsc_charge #(
    .PIN_SAMPLES (PIN_SAMPLES)
  ) u_charge (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .first       (first),
    .charge_lows (charge_lows_q),
    .cfg         (cfg),
    .volt_nx     (volt_nx),
    .chg_nx      (chg_nx)
  );

  // the SOC stage sees this beat's filtered voltage and charge status
  bsc_soc u_soc (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .raw_soc  (raw_soc_q),
    .filt_nx  (volt_nx.filt),
    .chg_nx   (chg_nx),
    .cfg      (cfg),
    .shown_nx (shown_nx)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_mv <= volt_nx.filt;
      charging    <= chg_nx.charging;
      plugged     <= chg_nx.plugged;
      connected   <= !chg_nx.charging && (volt_nx.filt < bsc_pkg::CONNECT_MAX_MV);
      shown_soc   <= shown_nx;
    end
  end

  // a held item never drops out while the result side is stalled
  a_inq_hold: assert property (@(posedge clk) disable iff (rst)
    inq_valid && !advance |=> inq_valid)
    else $error("input register lost a held item");

  // a result beat only appears after an item left the input register
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance))
    else $error("result beat without a source item");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced item not offered as a result");

  // connected implies the charge latch is clear
  a_conn_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(connected && charging))
    else $error("connected and charging both set");

endmodule

// ----- sv/bsc_regs.sv -----
// ----------------------------------------------------------------------------
// bsc_regs: APB configuration registers
// Eight threshold registers, written on the access phase, read back as is.
// ----------------------------------------------------------------------------
module bsc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bsc_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_mv              <= bsc_pkg::RST_EMPTY_MV;
      cfg.full_mv               <= bsc_pkg::RST_FULL_MV;
      cfg.outlier_mv            <= bsc_pkg::RST_OUTLIER_MV;
      cfg.plugged_abs_mv        <= bsc_pkg::RST_PLUGGED_ABS_MV;
      cfg.plugged_margin_mv     <= bsc_pkg::RST_PLUGGED_MARGIN_MV;
      cfg.baseline_track_max_mv <= bsc_pkg::RST_BASE_TRACK_MAX_MV;
      cfg.charging_band_min     <= bsc_pkg::RST_CHG_BAND_MIN;
      cfg.idle_high_max         <= bsc_pkg::RST_IDLE_HIGH_MAX;
    end else if (wr_en) begin
      unique case (idx)
        bsc_pkg::REG_EMPTY_MV:          cfg.empty_mv              <= pwdata[12:0];
        bsc_pkg::REG_FULL_MV:           cfg.full_mv               <= pwdata[12:0];
        bsc_pkg::REG_OUTLIER_MV:        cfg.outlier_mv            <= pwdata[9:0];
        bsc_pkg::REG_PLUGGED_ABS_MV:    cfg.plugged_abs_mv        <= pwdata[12:0];
        bsc_pkg::REG_PLUGGED_MARGIN_MV: cfg.plugged_margin_mv     <= pwdata[9:0];
        bsc_pkg::REG_BASE_TRACK_MAX_MV: cfg.baseline_track_max_mv <= pwdata[12:0];
        bsc_pkg::REG_CHG_BAND_MIN:      cfg.charging_band_min     <= pwdata[5:0];
        bsc_pkg::REG_IDLE_HIGH_MAX:     cfg.idle_high_max         <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bsc_pkg::REG_EMPTY_MV:          prdata = {19'd0, cfg.empty_mv};
      bsc_pkg::REG_FULL_MV:           prdata = {19'd0, cfg.full_mv};
      bsc_pkg::REG_OUTLIER_MV:        prdata = {22'd0, cfg.outlier_mv};
      bsc_pkg::REG_PLUGGED_ABS_MV:    prdata = {19'd0, cfg.plugged_abs_mv};
      bsc_pkg::REG_PLUGGED_MARGIN_MV: prdata = {22'd0, cfg.plugged_margin_mv};
      bsc_pkg::REG_BASE_TRACK_MAX_MV: prdata = {19'd0, cfg.baseline_track_max_mv};
      bsc_pkg::REG_CHG_BAND_MIN:      prdata = {26'd0, cfg.charging_band_min};
      bsc_pkg::REG_IDLE_HIGH_MAX:     prdata = {26'd0, cfg.idle_high_max};
      default:                        prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/bsc_volt.sv -----
// ----------------------------------------------------------------------------
// bsc_volt: voltage filter and baseline tracker
// Outlier-gated filter (gain 1/16 or 1/4) and slow-rising minimum baseline.
// ----------------------------------------------------------------------------
module bsc_volt (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          first,
  input  logic [12:0]   raw_mv,
  input  bsc_pkg::cfg_t cfg,
  output bsc_pkg::volt_t volt_nx
);

  logic [12:0] filt;
  logic [12:0] base;
  logic [7:0]  outlier_streak;

  logic [12:0] filt_next;
  logic [12:0] base_next;
  logic [7:0]  outlier_streak_next;

  logic signed [14:0] diff;
  logic signed [14:0] gap_test;
  logic signed [14:0] step_amt;
  logic signed [14:0] filt_sum;
  logic [7:0]         streak_inc;
  logic [12:0]        filt_upd;

  // signed divide by 2**sh, truncating toward zero
  function automatic logic signed [14:0] div_trunc(input logic signed [14:0] v,
                                                   input int unsigned sh);
    logic [14:0] mag;
    mag = v[14] ? 15'(-v) : 15'(v);
    mag = mag >> sh;
    return v[14] ? -$signed(mag) : $signed(mag);
  endfunction

  assign diff       = $signed({2'b00, raw_mv}) - $signed({2'b00, filt});
  assign gap_test   = diff + $signed({5'd0, cfg.outlier_mv});
  assign step_amt   = (diff < -bsc_pkg::FAST_GAP_MV) ? div_trunc(diff, 4) : div_trunc(diff, 2);
  assign filt_sum   = $signed({2'b00, filt}) + step_amt;
  assign filt_upd   = filt_sum[12:0];
  assign streak_inc = bsc_pkg::sat_inc(outlier_streak);

  always_comb begin
    filt_next           = filt;
    outlier_streak_next = outlier_streak;
    if (first) begin
      filt_next = raw_mv;
    end else if (filt == 13'd0) begin
      filt_next           = raw_mv;
      outlier_streak_next = 8'd0;
    end else if (gap_test < 0) begin
      // short dips are ignored until confirmed
      outlier_streak_next = streak_inc;
      if (streak_inc >= bsc_pkg::CONFIRM_COUNT) begin
        filt_next = filt_upd;
      end
    end else begin
      outlier_streak_next = 8'd0;
      filt_next           = filt_upd;
    end
  end

  always_comb begin
    base_next = base;
    if (first || base == 13'd0) begin
      base_next = filt_next;
    end else if (filt_next < base) begin
      base_next = filt_next;
    end else if (filt_next < cfg.baseline_track_max_mv && filt_next > base) begin
      base_next = base + ((filt_next - base) >> 5);
    end
  end

  assign volt_nx.filt = filt_next;
  assign volt_nx.base = base_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      filt           <= 13'd0;
      base           <= 13'd0;
      outlier_streak <= 8'd0;
    end else if (step) begin
      filt           <= filt_next;
      base           <= base_next;
      outlier_streak <= outlier_streak_next;
    end
  end

endmodule

// ----- sv/bsc_charge.sv -----
// ----------------------------------------------------------------------------
// bsc_charge: charge pin classifier and debounced latch
// Needs two agreeing classifications to flip; also judges external power.
// ----------------------------------------------------------------------------
module bsc_charge #(
  parameter int PIN_SAMPLES = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            first,
  input  logic [5:0]      charge_lows,
  input  bsc_pkg::cfg_t   cfg,
  input  bsc_pkg::volt_t  volt_nx,
  output bsc_pkg::charge_t chg_nx
);

  localparam logic [6:0] PinAll  = 7'(PIN_SAMPLES);
  localparam logic [6:0] BandTop = 7'(PIN_SAMPLES - 1);

  logic       latch;
  logic       last_class;
  logic [1:0] stable_count;

  logic       latch_next;
  logic       last_class_next;
  logic [1:0] stable_count_next;

  logic [6:0]  lows;
  logic        all_high;
  logic        in_band;
  logic        idle_low;
  logic [1:0]  cls;
  logic        r;
  logic [1:0]  sc_mid;
  logic [13:0] margin_lvl;
  logic        plug_volt;

  assign lows     = {1'b0, charge_lows};
  assign all_high = (lows == PinAll);
  assign in_band  = (lows >= {1'b0, cfg.charging_band_min}) && (lows <= BandTop);
  assign idle_low = (lows <= {1'b0, cfg.idle_high_max});

  always_comb begin
    priority if (all_high) cls = bsc_pkg::CLS_IDLE;
    else if (in_band)      cls = bsc_pkg::CLS_CHG;
    else if (idle_low)     cls = bsc_pkg::CLS_IDLE;
    else                   cls = bsc_pkg::CLS_HOLD;
  end

  assign r = (cls == bsc_pkg::CLS_CHG);

  always_comb begin
    latch_next        = latch;
    last_class_next   = last_class;
    stable_count_next = stable_count;
    sc_mid            = stable_count;
    if (first) begin
      latch_next        = r;
      last_class_next   = r;
      stable_count_next = bsc_pkg::STABLE_FULL;
    end else if (cls != bsc_pkg::CLS_HOLD) begin
      if (r == latch) begin
        sc_mid = bsc_pkg::STABLE_FULL;
      end else if (r == last_class) begin
        if (stable_count < bsc_pkg::STABLE_FULL) sc_mid = stable_count + 2'd1;
      end else begin
        last_class_next = r;
        sc_mid          = 2'd1;
      end
      stable_count_next = sc_mid;
      if (sc_mid >= bsc_pkg::STABLE_FULL) latch_next = r;
    end
  end

  // external power: pin activity, or a solid-high pin with a raised voltage
  assign margin_lvl = {1'b0, volt_nx.base} + {4'd0, cfg.plugged_margin_mv};
  assign plug_volt  = (volt_nx.filt >= cfg.plugged_abs_mv) ||
                      (volt_nx.base != 13'd0 && {1'b0, volt_nx.filt} >= margin_lvl);

  assign chg_nx.charging = latch_next;
  assign chg_nx.plugged  = in_band || idle_low || (all_high && plug_volt);

  always_ff @(posedge clk) begin
    if (rst) begin
      latch        <= 1'b0;
      last_class   <= 1'b0;
      stable_count <= bsc_pkg::STABLE_FULL;
    end else if (step) begin
      latch        <= latch_next;
      last_class   <= last_class_next;
      stable_count <= stable_count_next;
    end
  end

endmodule

// ----- sv/bsc_soc.sv -----
// ----------------------------------------------------------------------------
// bsc_soc: displayed state-of-charge smoother
// Fast rise, confirmed slow fall, hold while powered, empty/full forcing.
// ----------------------------------------------------------------------------
module bsc_soc (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [6:0]       raw_soc,
  input  logic [12:0]      filt_nx,
  input  bsc_pkg::charge_t chg_nx,
  input  bsc_pkg::cfg_t    cfg,
  output logic [6:0]       shown_nx
);

  logic       soc_valid;
  logic [6:0] shown;
  logic [7:0] drop_streak;
  logic [7:0] low_streak;

  logic [7:0] drop_streak_next;
  logic [7:0] low_streak_next;

  logic [6:0] up_gap;
  logic [9:0] up_prod;
  logic [6:0] down_gap;
  logic [6:0] shown_mid;
  logic [7:0] drop_inc;
  logic [7:0] low_inc;
  logic       is_low;
  logic       is_full;

  assign up_gap   = raw_soc - shown;
  assign up_prod  = {3'd0, up_gap} * 10'd6;
  assign down_gap = shown - raw_soc;
  assign drop_inc = bsc_pkg::sat_inc(drop_streak);
  assign low_inc  = bsc_pkg::sat_inc(low_streak);
  assign is_low   = ({1'b0, filt_nx} + bsc_pkg::EMPTY_MARGIN_MV) < {1'b0, cfg.empty_mv};
  assign is_full  = ({1'b0, filt_nx} + bsc_pkg::FULL_MARGIN_MV) >= {1'b0, cfg.full_mv};

  always_comb begin
    shown_mid        = shown;
    drop_streak_next = drop_streak;
    low_streak_next  = low_streak;
    shown_nx         = shown;
    if (!soc_valid) begin
      shown_nx         = raw_soc;
      drop_streak_next = 8'd0;
      low_streak_next  = 8'd0;
    end else begin
      if (raw_soc >= shown) begin
        drop_streak_next = 8'd0;
        shown_mid        = shown + {1'b0, up_prod[9:4]};
      end else if (chg_nx.charging || chg_nx.plugged) begin
        drop_streak_next = 8'd0;
      end else begin
        drop_streak_next = drop_inc;
        // fall at most one point per confirmed read
        if (drop_inc >= bsc_pkg::CONFIRM_COUNT && {1'b0, down_gap} >= bsc_pkg::SOC_DEC_GAP) begin
          shown_mid = shown - 7'd1;
        end
      end
      shown_nx = shown_mid;
      if (is_low) begin
        low_streak_next = low_inc;
        if (low_inc >= bsc_pkg::CONFIRM_COUNT) shown_nx = 7'd0;
      end else begin
        low_streak_next = 8'd0;
        if (is_full) shown_nx = bsc_pkg::SOC_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      soc_valid   <= 1'b0;
      shown       <= 7'd0;
      drop_streak <= 8'd0;
      low_streak  <= 8'd0;
    end else if (step) begin
      soc_valid   <= 1'b1;
      shown       <= shown_nx;
      drop_streak <= drop_streak_next;
      low_streak  <= low_streak_next;
    end
  end

endmodule
